>>> hw/rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = CHAR_W + ATTR_W;
  localparam int REQ_W   = 3;
  localparam int CBG_W   = 4;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CELL_W-1:0] KEEP_LOW_NIBBLE_ATTR = 16'h0FFF;

  localparam logic [ATTR_W-1:0] RESET_TEXT_COLOR = 8'd14;
  localparam logic [CBG_W-1:0]  RESET_CURSOR_BG  = 4'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_BG  = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT    = 3'd0,
    REQ_EOS    = 3'd1,
    REQ_CLEAR  = 3'd2,
    REQ_SETCUR = 3'd3,
    REQ_READ   = 3'd4
  } tcw_req_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_PUT,
    S_SCROLL,
    S_BOTTOM,
    S_HL_RD_OLD,
    S_HL_WR_OLD,
    S_HL_RD_NEW,
    S_HL_WR_NEW,
    S_RD_WAIT,
    S_DONE
  } tcw_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/text_console_writer_unit.sv
// Top level of the text console writer: request decode, cell store control and result word.
//
//  channel | direction | handshake           | word contents
//  --------+-----------+---------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/in_tready | tuser: req_type; tdata: char, row, column
//  out_    | master    | out_tvalid/tready   | tdata: write row, write col, char, attr
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index selects register, cfg_data value
//
// Steps per request: put character writes its cell, or on a wrap without scroll moves to
// the next row and writes it in S_PUT; newline moves to the next row; scroll copies every
// row one up and clears the bottom row, then puts a wrapped character; clear writes every
// cell; end of string or set cursor rewrite the old, then the new highlight cell. The cell
// store has a single read and a single write port; scroll copies one cell per cycle.
// After reset a clearing pass fills the store with spaces in colour 14; no request is
// taken meanwhile, configuration writes are.
// A finished result waits in the output register; the next request is taken and
// worked on meanwhile, and stalls only at its own result until the word is taken.
`default_nettype none

module text_console_writer_unit #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // request channel
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [tcw_pkg::IN_DATA_W-1:0]    in_tdata,  // char_code[7:0], target_row[12:8],
                                                           // target_col[19:13], zero pad
  input  wire logic [tcw_pkg::REQ_W-1:0]        in_tuser,  // req_type[2:0]
  // result channel
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [tcw_pkg::OUT_DATA_W-1:0]   out_tdata, // write_row[4:0], write_col[11:5],
                                                           // read_char[19:12], read_attr[27:20]
  // configuration channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [tcw_pkg::ATTR_W-1:0]       cfg_data
);

  import tcw_pkg::*;

  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(SCREEN_COLS - 1);
  localparam logic [COL_W:0]   COLS_EXT  = (COL_W + 1)'(SCREEN_COLS);
  localparam logic [AW-1:0]    COLS_A    = AW'(SCREEN_COLS);
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]    COPY_END  = AW'(CELLS - SCREEN_COLS);

  function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] r);
    clamp_row = (r > LAST_ROW) ? LAST_ROW : r;
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic [COL_W-1:0] c);
    clamp_col = (c > LAST_COL) ? LAST_COL : c;
  endfunction

  // FSM and position registers
  tcw_state_t       state_r, state_nxt;
  logic [REQ_W-1:0] req_r;
  logic [CHAR_W-1:0] char_r;
  logic [ROW_W-1:0] trow_r;
  logic [COL_W-1:0] tcol_r;

  logic [ROW_W-1:0] wrow_r, wrow_nxt;
  logic [COL_W-1:0] wcol_r, wcol_nxt;
  logic [ROW_W-1:0] hrow_r, hrow_nxt;
  logic [COL_W-1:0] hcol_r, hcol_nxt;
  logic [ROW_W-1:0] grow_r, grow_nxt;   // highlight target
  logic [COL_W-1:0] gcol_r, gcol_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic             char_pend_r, char_pend_nxt;
  logic             init_r, init_nxt;

  logic [ATTR_W-1:0] text_color_r;
  logic [CBG_W-1:0]  cursor_bg_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_DATA_W-1:0] pend_data_r, pend_data_nxt;

  // cell store
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // shared decode
  logic              in_acc;
  logic              is_nl, at_last_row, col_full, sweep_end, copy_end, slot_free;
  logic              finish;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [AW-1:0]     cell_addr;
  logic [ATTR_W-1:0] clear_color;
  logic [CHAR_W-1:0] fin_char;
  logic [ATTR_W-1:0] fin_attr;
  tcw_state_t        finish_go;

  assign in_acc      = in_tvalid && in_tready;
  assign in_tready   = (state_r == S_IDLE);
  assign cfg_ready   = 1'b1;
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;

  assign is_nl       = (char_r == NEWLINE_CODE);
  assign at_last_row = (wrow_r == LAST_ROW);
  assign col_full    = ({1'b0, wcol_r} >= COLS_EXT);
  assign sweep_end   = (cnt_r == LAST_CELL);
  assign copy_end    = (cnt_r == COPY_END);
  assign slot_free   = !out_valid_r || out_tready;
  assign finish_go   = slot_free ? S_IDLE : S_DONE;
  assign clear_color = init_r ? RESET_TEXT_COLOR : text_color_r;

  // Pick the cell that the current step addresses, then flatten it.
  always_comb begin
    if (state_r == S_EXEC && req_r == REQ_READ) begin
      sel_row = clamp_row(trow_r);
      sel_col = clamp_col(tcol_r);
    end else if (state_r == S_HL_RD_OLD || state_r == S_HL_WR_OLD ||
                 state_r == S_HL_RD_NEW || state_r == S_HL_WR_NEW) begin
      sel_row = hrow_r;
      sel_col = hcol_r;
    end else begin
      sel_row = wrow_r;
      sel_col = clamp_col(wcol_r);
    end
  end

  assign cell_addr = AW'(sel_row) * COLS_A + AW'(sel_col);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sweep_end) state_nxt = init_r ? S_IDLE : finish_go;
      end
      S_IDLE: begin
        if (in_acc) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (req_r)
          REQ_PUT: begin
            if (is_nl) begin
              state_nxt = at_last_row ? S_SCROLL : finish_go;
            end else if (col_full) begin
              state_nxt = at_last_row ? S_SCROLL : S_PUT;
            end else begin
              state_nxt = finish_go;
            end
          end
          REQ_EOS, REQ_SETCUR: state_nxt = S_HL_RD_OLD;
          REQ_CLEAR:           state_nxt = S_CLEAR;
          REQ_READ:            state_nxt = S_RD_WAIT;
          default:             state_nxt = finish_go;
        endcase
      end
      S_PUT:       state_nxt = finish_go;
      S_SCROLL: begin
        if (copy_end) state_nxt = S_BOTTOM;
      end
      S_BOTTOM: begin
        if (sweep_end) state_nxt = char_pend_r ? S_PUT : finish_go;
      end
      S_HL_RD_OLD: state_nxt = S_HL_WR_OLD;
      S_HL_WR_OLD: state_nxt = S_HL_RD_NEW;
      S_HL_RD_NEW: state_nxt = S_HL_WR_NEW;
      S_HL_WR_NEW: state_nxt = finish_go;
      S_RD_WAIT:   state_nxt = finish_go;
      S_DONE: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath and store controls
  always_comb begin
    wrow_nxt      = wrow_r;
    wcol_nxt      = wcol_r;
    hrow_nxt      = hrow_r;
    hcol_nxt      = hcol_r;
    grow_nxt      = grow_r;
    gcol_nxt      = gcol_r;
    cnt_nxt       = cnt_r;
    char_pend_nxt = char_pend_r;
    init_nxt      = init_r;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr;
    ram_wdata     = {text_color_r, char_r};
    ram_raddr     = cell_addr;
    finish        = 1'b0;
    fin_char      = '0;
    fin_attr      = '0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {clear_color, SPACE_CODE};
        if (sweep_end) begin
          init_nxt = 1'b0;
          finish   = !init_r;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_EXEC: begin
        case (req_r)
          REQ_PUT: begin
            if (is_nl || col_full) begin
              // new line: advance the row, or scroll on the last one
              wcol_nxt = '0;
              if (!at_last_row) begin
                wrow_nxt = wrow_r + ROW_W'(1);
                finish   = is_nl;
              end else begin
                cnt_nxt       = '0;
                char_pend_nxt = !is_nl;
              end
            end else begin
              ram_we   = 1'b1;
              wcol_nxt = wcol_r + COL_W'(1);
              finish   = 1'b1;
            end
          end
          REQ_EOS: begin
            grow_nxt = wrow_r;
            gcol_nxt = clamp_col(wcol_r);
          end
          REQ_SETCUR: begin
            grow_nxt = clamp_row(trow_r);
            gcol_nxt = clamp_col(tcol_r);
          end
          REQ_CLEAR: cnt_nxt = '0;
          REQ_READ:  ;
          default:   finish = 1'b1;
        endcase
      end
      S_PUT: begin
        ram_we   = 1'b1;
        wcol_nxt = wcol_r + COL_W'(1);
        finish   = 1'b1;
      end
      S_SCROLL: begin
        // read one row below, write the word read last cycle one step behind
        ram_raddr = copy_end ? cnt_r : cnt_r + COLS_A;
        if (cnt_r != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!copy_end) cnt_nxt = cnt_r + AW'(1);
      end
      S_BOTTOM: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r;
        ram_wdata = {text_color_r, SPACE_CODE};
        if (sweep_end) begin
          char_pend_nxt = 1'b0;
          finish        = !char_pend_r;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_HL_WR_OLD: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & KEEP_LOW_NIBBLE_ATTR;
        hrow_nxt  = grow_r;
        hcol_nxt  = gcol_r;
      end
      S_HL_WR_NEW: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | {cursor_bg_r, (CELL_W - CBG_W)'(0)};
        finish    = 1'b1;
      end
      S_RD_WAIT: begin
        fin_char = ram_rdata[CHAR_W-1:0];
        fin_attr = ram_rdata[CELL_W-1:CHAR_W];
        finish   = 1'b1;
      end
      default: ;
    endcase
  end

  // Result word: load straight into the output register when it is free,
  // otherwise hold it until the waiting word is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_data_nxt = pend_data_r;
    if (finish) begin
      if (slot_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {4'b0, fin_attr, fin_char, wcol_nxt, wrow_nxt};
      end else begin
        pend_data_nxt = {4'b0, fin_attr, fin_char, wcol_nxt, wrow_nxt};
      end
    end else if (state_r == S_DONE && out_tready) begin
      out_data_nxt = pend_data_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      wrow_r       <= '0;
      wcol_r       <= '0;
      hrow_r       <= '0;
      hcol_r       <= '0;
      cnt_r        <= '0;
      char_pend_r  <= 1'b0;
      init_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      text_color_r <= RESET_TEXT_COLOR;
      cursor_bg_r  <= RESET_CURSOR_BG;
    end else begin
      state_r     <= state_nxt;
      wrow_r      <= wrow_nxt;
      wcol_r      <= wcol_nxt;
      hrow_r      <= hrow_nxt;
      hcol_r      <= hcol_nxt;
      cnt_r       <= cnt_nxt;
      char_pend_r <= char_pend_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_COLOR: text_color_r <= cfg_data;
          CFG_CURSOR_BG:  cursor_bg_r  <= cfg_data[CBG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tuser;
      char_r <= in_tdata[CHAR_W-1:0];
      trow_r <= in_tdata[CHAR_W +: ROW_W];
      tcol_r <= in_tdata[CHAR_W + ROW_W +: COL_W];
    end
    grow_r      <= grow_nxt;
    gcol_r      <= gcol_nxt;
    out_data_r  <= out_data_nxt;
    pend_data_r <= pend_data_nxt;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Write position and highlight stay on the screen.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wrow_r <= LAST_ROW) && ({1'b0, wcol_r} <= COLS_EXT) &&
    (hrow_r <= LAST_ROW) && (hcol_r <= LAST_COL))
    else $error("write or highlight position off screen");

  // Every store write lands inside the screen.
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr <= LAST_CELL))
    else $error("cell store write out of range");

  // A result parked in the hold register only while the output word waits.
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> out_valid_r)
    else $error("result held with an empty output register");

  // The scroll copy never runs past the start of the bottom row.
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (cnt_r <= COPY_END))
    else $error("scroll copy overran");

endmodule

`default_nettype wire

>>> hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
